@@ hdl/ble_pkg.sv @@
// Package: shared types, constants and the control-word table for the election node.
package ble_pkg;

  localparam int NODES     = 16;
  localparam int ID_W      = 4;
  localparam int MAX_SENDS = 16;
  localparam int CNT_W     = 5;
  localparam int DATA_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [DATA_W-1:0] PING_PERIOD_RST = 16'd1000;
  localparam logic [DATA_W-1:0] TIMEOUT_RST     = 16'd3000;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_MSG  = 2'd1,
    MODE_INIT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_ANSWER   = 3'd0,
    KIND_ELECTION = 3'd1,
    KIND_PING     = 3'd2,
    KIND_PONG     = 3'd3,
    KIND_VICTORY  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ROLE_FOLLOWER = 2'd0,
    ROLE_ELECTING = 2'd1,
    ROLE_LEADER   = 2'd2
  } role_t;

  typedef enum logic [2:0] {
    CFG_NODE_ID      = 3'd0,
    CFG_NEIGHBOUR    = 3'd1,
    CFG_START_LEADER = 3'd2,
    CFG_START_ROLE   = 3'd3,
    CFG_PING_PERIOD  = 3'd4,
    CFG_TIMEOUT      = 3'd5
  } cfg_idx_t;

  // Input and result beats
  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] msg_from;
    logic [2:0]      msg_kind;
  } in_item_t;

  typedef struct packed {
    logic            send_valid;
    logic [ID_W-1:0] send_to;
    logic [2:0]      send_kind;
    logic [1:0]      role_now;
    logic [ID_W-1:0] leader_now;
    logic            last_result;
  } out_item_t;

  // Microprogram
  typedef enum logic [2:0] {
    ST_DECIDE = 3'd0,
    ST_TVIC   = 3'd1,
    ST_TELEC  = 3'd2,
    ST_TVIC2  = 3'd3,
    ST_TPING  = 3'd4,
    ST_MANS   = 3'd5,
    ST_MPONG  = 3'd6,
    ST_FINISH = 3'd7
  } step_t;

  typedef enum logic [1:0] {
    OP_DECIDE = 2'd0,
    OP_SCAN   = 2'd1,
    OP_SINGLE = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    TGT_ALL    = 2'd0,
    TGT_HIGHER = 2'd1,
    TGT_LEADER = 2'd2,
    TGT_FROM   = 2'd3
  } tgt_t;

  typedef enum logic [2:0] {
    COND_NONE  = 3'd0,
    COND_E_EXP = 3'd1,
    COND_P_EXP = 3'd2,
    COND_VICT2 = 3'd3,
    COND_PING  = 3'd4,
    COND_ANS   = 3'd5,
    COND_PONG  = 3'd6
  } cond_t;

  typedef struct packed {
    op_t   op;
    kind_t kind;
    tgt_t  tgt;
    cond_t cond;
    step_t nxt;
  } cword_t;

  // Flags latched by the decide step, tested by later steps
  typedef struct packed {
    logic e_exp;
    logic p_exp;
    logic vict2;
    logic ping;
    logic ans;
    logic pong;
  } flags_t;

  function automatic cword_t ucode(input step_t st);
    cword_t cw;
    unique case (st)
      ST_DECIDE: cw = '{OP_DECIDE, KIND_ANSWER,   TGT_ALL,    COND_NONE,  ST_FINISH};
      ST_TVIC:   cw = '{OP_SCAN,   KIND_VICTORY,  TGT_ALL,    COND_E_EXP, ST_TELEC};
      ST_TELEC:  cw = '{OP_SCAN,   KIND_ELECTION, TGT_HIGHER, COND_P_EXP, ST_TVIC2};
      ST_TVIC2:  cw = '{OP_SCAN,   KIND_VICTORY,  TGT_ALL,    COND_VICT2, ST_TPING};
      ST_TPING:  cw = '{OP_SINGLE, KIND_PING,     TGT_LEADER, COND_PING,  ST_FINISH};
      ST_MANS:   cw = '{OP_SINGLE, KIND_ANSWER,   TGT_FROM,   COND_ANS,   ST_MPONG};
      ST_MPONG:  cw = '{OP_SINGLE, KIND_PONG,     TGT_FROM,   COND_PONG,  ST_FINISH};
      ST_FINISH: cw = '{OP_FINISH, KIND_ANSWER,   TGT_ALL,    COND_NONE,  ST_FINISH};
      default:   cw = '{OP_FINISH, KIND_ANSWER,   TGT_ALL,    COND_NONE,  ST_FINISH};
    endcase
    return cw;
  endfunction

endpackage

@@ hdl/bully_leader_election_unit.sv @@
// Top level: one bully election node run by a microcoded sequencer.
//
//   channel | direction | handshake             | beat
//   in_     | input     | in_valid / in_ready   | in_item_t (mode, msg_from, msg_kind)
//   out_    | output    | out_valid / out_ready | out_item_t (one per message sent, or one empty closing beat)
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// One item at a time: a decide step, then each broadcast step taken walks every
// node id (up to three scans on a tick), each single send takes its step, and a
// closing step ends the item; a skipped step is still visited. The id scan sets the rate.
// Reset (rst_n low at a clock edge) restores the idle node and register defaults.
// A stalled output holds the sequencer only when a send or the closing beat needs the slot.
module bully_leader_election_unit
  import ble_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  // Configuration registers
  logic [ID_W-1:0]   node_id_r;
  logic [NODES-1:0]  mask_r;
  logic [ID_W-1:0]   start_leader_r;
  logic [1:0]        start_role_r;
  logic [DATA_W-1:0] ping_period_r;
  logic [DATA_W-1:0] timeout_r;

  // Node state
  role_t             role_r, role_nxt;
  logic [ID_W-1:0]   leader_r, leader_nxt;
  logic [DATA_W-1:0] period_r, period_nxt;
  logic [DATA_W-1:0] pwait_r, pwait_nxt;
  logic              parmed_r, parmed_nxt;
  logic [DATA_W-1:0] ewait_r, ewait_nxt;
  logic              earmed_r, earmed_nxt;

  // Sequencer
  logic              busy_r, busy_nxt;
  step_t             upc_r, upc_nxt;
  logic [ID_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  in_item_t          item_r;
  flags_t            flags_r, flags_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [ID_W-1:0]   hold_to_r, hold_to_nxt;
  kind_t             hold_kind_r, hold_kind_nxt;
  logic              out_v_r, out_v_nxt;
  out_item_t         out_r, out_nxt;

  cword_t            cw;
  logic              cond_ok;
  logic              sel;
  logic              want_emit;
  logic              can_emit;
  logic              out_free;
  logic              higher;
  logic              ping_fire;
  logic [DATA_W-1:0] period_inc;
  logic [ID_W-1:0]   tgt_id;
  logic [NODES-1:0]  above;

  assign in_ready  = !busy_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign out_free  = !out_v_r || out_ready;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r      <= '0;
      mask_r         <= '0;
      start_leader_r <= '0;
      start_role_r   <= '0;
      ping_period_r  <= PING_PERIOD_RST;
      timeout_r      <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NODE_ID:      node_id_r      <= cfg_wdata[ID_W-1:0];
        CFG_NEIGHBOUR:    mask_r         <= cfg_wdata[NODES-1:0];
        CFG_START_LEADER: start_leader_r <= cfg_wdata[ID_W-1:0];
        CFG_START_ROLE:   start_role_r   <= cfg_wdata[1:0];
        CFG_PING_PERIOD:  ping_period_r  <= cfg_wdata;
        CFG_TIMEOUT:      timeout_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Mark ids above our own that are connected
  always_comb begin
    for (int i = 0; i < NODES; i++) begin
      above[i] = mask_r[i] && (ID_W'(i) > node_id_r);
    end
    higher = |above;
  end

  // Decode the current control word
  always_comb begin
    cw = ucode(upc_r);
    unique case (cw.cond)
      COND_E_EXP: cond_ok = flags_r.e_exp;
      COND_P_EXP: cond_ok = flags_r.p_exp;
      COND_VICT2: cond_ok = flags_r.vict2;
      COND_PING:  cond_ok = flags_r.ping;
      COND_ANS:   cond_ok = flags_r.ans;
      COND_PONG:  cond_ok = flags_r.pong;
      default:    cond_ok = 1'b0;
    endcase
    unique case (cw.tgt)
      TGT_LEADER: tgt_id = leader_r;
      TGT_FROM:   tgt_id = item_r.msg_from;
      default:    tgt_id = idx_r;
    endcase
    sel = mask_r[idx_r] && (idx_r != node_id_r)
          && ((cw.tgt != TGT_HIGHER) || (idx_r > node_id_r));
    want_emit = busy_r && cond_ok && (cnt_r < CNT_W'(MAX_SENDS))
                && ((cw.op == OP_SINGLE) || ((cw.op == OP_SCAN) && sel));
    can_emit  = !hold_v_r || out_free;
  end

  // Sequence the steps and update node state
  always_comb begin
    role_nxt      = role_r;
    leader_nxt    = leader_r;
    period_nxt    = period_r;
    pwait_nxt     = pwait_r;
    parmed_nxt    = parmed_r;
    ewait_nxt     = ewait_r;
    earmed_nxt    = earmed_r;
    busy_nxt      = busy_r;
    upc_nxt       = upc_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    flags_nxt     = flags_r;
    hold_v_nxt    = hold_v_r;
    hold_to_nxt   = hold_to_r;
    hold_kind_nxt = hold_kind_r;
    out_v_nxt     = out_ready ? 1'b0 : out_v_r;
    out_nxt       = out_r;
    ping_fire     = 1'b0;
    period_inc    = period_r + DATA_W'(1);

    if (!busy_r) begin
      // Accept a new beat
      if (in_valid) begin
        busy_nxt = 1'b1;
        upc_nxt  = ST_DECIDE;
      end
    end else begin
      // Move a held send out when a new one takes its place
      if (want_emit && can_emit) begin
        if (hold_v_r) begin
          out_v_nxt = 1'b1;
          out_nxt   = '{1'b1, hold_to_r, hold_kind_r, role_r, leader_r, 1'b0};
        end
        hold_v_nxt    = 1'b1;
        hold_to_nxt   = tgt_id;
        hold_kind_nxt = cw.kind;
        cnt_nxt       = cnt_r + CNT_W'(1);
      end

      unique case (cw.op)
        OP_DECIDE: begin
          flags_nxt = '0;
          unique case (item_r.mode)
            MODE_TICK: begin
              // Election countdown
              if (earmed_r) begin
                if (ewait_r <= DATA_W'(1)) begin
                  earmed_nxt      = 1'b0;
                  ewait_nxt       = '0;
                  role_nxt        = ROLE_LEADER;
                  leader_nxt      = node_id_r;
                  flags_nxt.e_exp = 1'b1;
                end else begin
                  ewait_nxt = ewait_r - DATA_W'(1);
                end
              end
              // Ping countdown; expiry starts an election, or makes us leader when no higher node is connected
              if (parmed_r) begin
                if (pwait_r <= DATA_W'(1)) begin
                  parmed_nxt      = 1'b0;
                  pwait_nxt       = '0;
                  flags_nxt.p_exp = 1'b1;
                  if (higher) begin
                    role_nxt   = ROLE_ELECTING;
                    ewait_nxt  = timeout_r;
                    earmed_nxt = 1'b1;
                  end else begin
                    role_nxt        = ROLE_LEADER;
                    leader_nxt      = node_id_r;
                    earmed_nxt      = 1'b0;
                    ewait_nxt       = '0;
                    flags_nxt.vict2 = 1'b1;
                  end
                end else begin
                  pwait_nxt = pwait_r - DATA_W'(1);
                end
              end
              // Heartbeat period
              if (period_inc >= ping_period_r) begin
                period_nxt = '0;
                if (role_nxt == ROLE_FOLLOWER) begin
                  ping_fire  = 1'b1;
                  pwait_nxt  = timeout_r;
                  parmed_nxt = 1'b1;
                end
              end else begin
                period_nxt = period_inc;
              end
              flags_nxt.ping = ping_fire && (leader_nxt != node_id_r);
              upc_nxt        = ST_TVIC;
            end
            MODE_MSG: begin
              unique case (item_r.msg_kind)
                KIND_ANSWER: begin
                  if (role_r == ROLE_ELECTING) begin
                    earmed_nxt = 1'b0;
                    ewait_nxt  = '0;
                    role_nxt   = ROLE_FOLLOWER;
                  end
                end
                KIND_ELECTION: flags_nxt.ans  = 1'b1;
                KIND_PING:     flags_nxt.pong = 1'b1;
                KIND_PONG: begin
                  if (role_r == ROLE_FOLLOWER) begin
                    parmed_nxt = 1'b0;
                    pwait_nxt  = '0;
                  end
                end
                KIND_VICTORY: begin
                  earmed_nxt = 1'b0;
                  ewait_nxt  = '0;
                  role_nxt   = ROLE_FOLLOWER;
                  leader_nxt = item_r.msg_from;
                end
                default: ;
              endcase
              upc_nxt = ST_MANS;
            end
            MODE_INIT: begin
              role_nxt   = (start_role_r <= 2'd2) ? role_t'(start_role_r) : ROLE_FOLLOWER;
              leader_nxt = start_leader_r;
              period_nxt = '0;
              pwait_nxt  = '0;
              parmed_nxt = 1'b0;
              ewait_nxt  = '0;
              earmed_nxt = 1'b0;
              upc_nxt    = cw.nxt;
            end
            default: upc_nxt = cw.nxt;
          endcase
        end
        OP_SCAN: begin
          // Walk the ids one per cycle; stall only on a blocked send
          if (!cond_ok) begin
            upc_nxt = cw.nxt;
          end else if (!want_emit || can_emit) begin
            if (idx_r == ID_W'(NODES - 1)) begin
              idx_nxt = '0;
              upc_nxt = cw.nxt;
            end else begin
              idx_nxt = idx_r + ID_W'(1);
            end
          end
        end
        OP_SINGLE: begin
          if (!want_emit || can_emit) begin
            upc_nxt = cw.nxt;
          end
        end
        OP_FINISH: begin
          // Drain the held send, or an empty beat, as the last result
          if (out_free) begin
            out_v_nxt = 1'b1;
            if (hold_v_r) begin
              out_nxt = '{1'b1, hold_to_r, hold_kind_r, role_r, leader_r, 1'b1};
            end else begin
              out_nxt = '{1'b0, '0, 3'd0, role_r, leader_r, 1'b1};
            end
            hold_v_nxt = 1'b0;
            cnt_nxt    = '0;
            idx_nxt    = '0;
            busy_nxt   = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      role_r   <= ROLE_FOLLOWER;
      leader_r <= '0;
      period_r <= '0;
      pwait_r  <= '0;
      parmed_r <= 1'b0;
      ewait_r  <= '0;
      earmed_r <= 1'b0;
      busy_r   <= 1'b0;
      upc_r    <= ST_DECIDE;
      idx_r    <= '0;
      cnt_r    <= '0;
      flags_r  <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      role_r   <= role_nxt;
      leader_r <= leader_nxt;
      period_r <= period_nxt;
      pwait_r  <= pwait_nxt;
      parmed_r <= parmed_nxt;
      ewait_r  <= ewait_nxt;
      earmed_r <= earmed_nxt;
      busy_r   <= busy_nxt;
      upc_r    <= upc_nxt;
      idx_r    <= idx_nxt;
      cnt_r    <= cnt_nxt;
      flags_r  <= flags_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !busy_r) begin
      item_r <= in_data;
    end
    hold_to_r   <= hold_to_nxt;
    hold_kind_r <= hold_kind_nxt;
    out_r       <= out_nxt;
  end

`ifndef SYNTHESIS
  // Send count never passes the cap
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SENDS))
    else $error("send count above cap");

  // Idle sequencer holds no pending send
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (!hold_v_r && cnt_r == '0 && idx_r == '0))
    else $error("idle with pending send");

  // An empty result always closes its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.send_valid) |-> out_r.last_result)
    else $error("empty result not last");

  // An accepted beat starts at the decide step
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (busy_r && upc_r == ST_DECIDE))
    else $error("item did not start at decide");
`endif

endmodule
